// ----- rtl/hbw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbw_pkg
// Shared types, register indexes and reset values for the heartbeat watchdog.
// ----------------------------------------------------------------------------
package hbw_pkg;

  // Channel count and fixed field widths
  localparam int NUM_MODULES = 6;
  localparam int MOD_IDX_W   = 3;
  localparam int TIMEOUT_W   = 16;
  localparam int IN_TIME_W   = 32;
  localparam int COUNT_W     = 4;   // holds any cap up to 15
  localparam int OUT_COUNT_W = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Parameter defaults
  localparam int MAX_COUNTED_ERRORS_DEF = 8;
  localparam int TIME_BITS_DEF          = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CH5 = 3'd6;

  // Opcodes
  localparam logic OP_CHECK     = 1'b0;
  localparam logic OP_HEARTBEAT = 1'b1;

  typedef logic [NUM_MODULES-1:0]                mod_mask_t;
  typedef logic [NUM_MODULES-1:0][TIMEOUT_W-1:0] timeout_arr_t;

  // Reset values
  localparam mod_mask_t    ENABLE_MASK_RST = 6'h3F;
  localparam timeout_arr_t TIMEOUT_RST     = {16'd4000, 16'd4000, 16'd4000,
                                              16'd500,  16'd500,  16'd500};

  // Configuration seen by the sequencer
  typedef struct packed {
    mod_mask_t    enable_mask;
    timeout_arr_t timeout;
  } cfg_t;

endpackage : hbw_pkg
`default_nettype wire

// ----- rtl/hbw_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbw_cfg_regs
// Enable mask and per-module timeout registers behind a plain write port.
// ----------------------------------------------------------------------------
module hbw_cfg_regs
  import hbw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  mod_mask_t    enable_mask_r, enable_mask_nxt;
  timeout_arr_t timeout_r, timeout_nxt;
  logic [MOD_IDX_W-1:0] ch;

  assign ch = MOD_IDX_W'(cfg_index - REG_TIMEOUT_CH0);

  // Register decode; indexes past the last timeout are dropped
  always_comb begin
    enable_mask_nxt = enable_mask_r;
    timeout_nxt     = timeout_r;
    if (cfg_we) begin
      if (cfg_index == REG_ENABLE_MASK) begin
        enable_mask_nxt = cfg_wdata[NUM_MODULES-1:0];
      end else if (cfg_index inside {[REG_TIMEOUT_CH0:REG_TIMEOUT_CH5]}) begin
        timeout_nxt[ch] = cfg_wdata[TIMEOUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r <= ENABLE_MASK_RST;
      timeout_r     <= TIMEOUT_RST;
    end else begin
      enable_mask_r <= enable_mask_nxt;
      timeout_r     <= timeout_nxt;
    end
  end

  assign cfg.enable_mask = enable_mask_r;
  assign cfg.timeout     = timeout_r;

endmodule : hbw_cfg_regs
`default_nettype wire

// ----- rtl/hbw_deadline_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbw_deadline_cmp
// Shared deadline unit: flags now > seen + limit, sum kept one bit wider.
// ----------------------------------------------------------------------------
module hbw_deadline_cmp
  import hbw_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [TIME_BITS-1:0] seen,
  input  wire logic [TIMEOUT_W-1:0] limit,
  output logic                      expired
);

  logic [TIME_BITS:0] deadline;

  // Wide add then compare, no wrap handling
  assign deadline = {1'b0, seen} + (TIME_BITS+1)'(limit);
  assign expired  = {1'b0, now} > deadline;

endmodule : hbw_deadline_cmp
`default_nettype wire

// ----- rtl/module_heartbeat_watchdog.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// module_heartbeat_watchdog
// Six-module liveness watchdog: heartbeats record times, checks mark modules
// lost or found again and keep a count of marks.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  opcode, module_index, current_time
//   out_     output     out_valid/out_stall lost_mask, error_count, any_error
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// A heartbeat steps through accept and result load. A check steps through
// accept, each module in turn through the single deadline compare unit, load.
// Synchronous active-low reset clears state, marks, count and last-seen times.
// in_stall is high from accept until the result is loaded into the output
// register; loading waits while a previous result is held by out_stall.
// ----------------------------------------------------------------------------
module module_heartbeat_watchdog
  import hbw_pkg::*;
#(
  parameter int MAX_COUNTED_ERRORS = MAX_COUNTED_ERRORS_DEF,
  parameter int TIME_BITS          = TIME_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input items
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_opcode,
  input  wire logic [MOD_IDX_W-1:0]   in_module_index,
  input  wire logic [IN_TIME_W-1:0]   in_current_time,
  // result items
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [NUM_MODULES-1:0]      out_lost_mask,
  output logic [OUT_COUNT_W-1:0]      out_error_count,
  output logic                        out_any_error,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_VISIT  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam logic [MOD_IDX_W-1:0] LAST_MOD = MOD_IDX_W'(NUM_MODULES - 1);
  localparam logic [COUNT_W-1:0]   CAP      = COUNT_W'(MAX_COUNTED_ERRORS);

  cfg_t cfg;

  logic [1:0]           state_r, state_nxt;
  logic [MOD_IDX_W-1:0] idx_r, idx_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] now_in;
  mod_mask_t            lost_r, lost_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [TIME_BITS-1:0] last_seen_r [NUM_MODULES];

  logic                 out_valid_r, out_valid_nxt;
  mod_mask_t            out_lost_r;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic                 out_any_r;

  logic in_accept, out_free, expired, hb_write;

  hbw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hbw_deadline_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .now     (now_r),
    .seen    (last_seen_r[idx_r]),
    .limit   (cfg.timeout[idx_r]),
    .expired (expired)
  );

  // Fit the incoming time to the stored width
  generate
    if (TIME_BITS <= IN_TIME_W) begin : g_time_trunc
      assign now_in = in_current_time[TIME_BITS-1:0];
    end else begin : g_time_ext
      assign now_in = TIME_BITS'(in_current_time);
    end
  endgenerate

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign hb_write  = in_accept && (in_opcode == OP_HEARTBEAT) &&
                     (in_module_index < MOD_IDX_W'(NUM_MODULES));

  // Sequencer: one module visited per cycle in a check
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    lost_nxt      = lost_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          now_nxt = now_in;
          idx_nxt = '0;
          if (in_opcode == OP_CHECK) begin
            state_nxt = ST_VISIT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_VISIT: begin
        if (cfg.enable_mask[idx_r]) begin
          if (expired) begin
            if ((count_r < CAP) && !lost_r[idx_r]) begin
              lost_nxt[idx_r] = 1'b1;
              count_nxt       = count_r + 1'b1;
            end
          end else if (lost_r[idx_r]) begin
            lost_nxt[idx_r] = 1'b0;
            count_nxt       = count_r - 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_MOD) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and watchdog state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      lost_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      lost_r      <= lost_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Last-seen times, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MODULES; i++) begin
        last_seen_r[i] <= '0;
      end
    end else if (hb_write) begin
      last_seen_r[in_module_index] <= now_in;
    end
  end

  // Payload registers: time latch and result
  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if ((state_r == ST_FINISH) && out_free) begin
      out_lost_r  <= lost_r;
      out_count_r <= count_r[OUT_COUNT_W-1:0];
      out_any_r   <= (count_r != '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lost_mask   = out_lost_r;
  assign out_error_count = out_count_r;
  assign out_any_error   = out_any_r;

endmodule : module_heartbeat_watchdog
`default_nettype wire
